@@ hw/rtl/sliding_window_avg_max_min_unit_macros.svh @@
// Assertion macros used by the checker file of the sliding window unit.
`ifndef SLIDING_WINDOW_AVG_MAX_MIN_UNIT_MACROS_SVH
`define SLIDING_WINDOW_AVG_MAX_MIN_UNIT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define SWAMM_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// A condition in one cycle that implies a condition in the next cycle.
`define SWAMM_ASSERT_NEXT(lbl, cond, conseq, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

@@ hw/rtl/swamm_pkg.sv @@
package swamm_pkg;

    localparam int WINDOW      = 8;
    localparam int SAMPLE_BITS = 24;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

endpackage

@@ hw/rtl/sliding_window_avg_max_min_unit.sv @@
// An input transfer starts a scan of the window, then a division; the result then waits
// until the output register is free, and no new sample is taken before that. The single
// accumulate and compare unit scans one stored sample per cycle; a radix-16 divider follows.
// Reset: rst_n is asynchronous and active low; the window is emptied and the unit is idle.
// Sample store contents are not cleared; only written entries are ever read.
module sliding_window_avg_max_min_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  swamm_pkg::sample_t sample,
    output logic               out_valid,
    input  logic               out_ready,
    output swamm_pkg::sample_t sample_echo,
    output swamm_pkg::sample_t window_average,
    output swamm_pkg::sample_t window_maximum,
    output swamm_pkg::sample_t window_minimum
);
    import swamm_pkg::*;

    // Widths that follow from the window length and the sample width.
    localparam int IDX_BITS   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_BITS   = $clog2(WINDOW + 1);
    localparam int SUM_BITS   = SAMPLE_BITS + $clog2(WINDOW);
    localparam int DIV_STEPS  = 4;
    localparam int DIV_CYCLES = (SUM_BITS + DIV_STEPS - 1) / DIV_STEPS;
    localparam int DIV_BITS   = DIV_CYCLES * DIV_STEPS;
    localparam int DCNT_BITS  = $clog2(DIV_CYCLES) + 1;
    localparam int REM_BITS   = CNT_BITS + 1;

    // The sequencer: idle (ready for a transfer), scan the window, divide, deliver.
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    // Ring index advance that wraps at the window length.
    function automatic logic [IDX_BITS-1:0] idx_inc(input logic [IDX_BITS-1:0] idx);
        logic [IDX_BITS-1:0] res;
        if (idx == IDX_BITS'(WINDOW - 1)) begin
            res = '0;
        end else begin
            res = idx + 1'b1;
        end
        return res;
    endfunction

    // Control state.
    state_t                state_reg, state_next;
    logic [IDX_BITS-1:0]   newest_reg, newest_next;
    logic [IDX_BITS-1:0]   oldest_reg, oldest_next;
    logic [CNT_BITS-1:0]   fill_reg, fill_next;
    logic [IDX_BITS-1:0]   scan_addr_reg, scan_addr_next;
    logic [CNT_BITS-1:0]   issue_cnt_reg, issue_cnt_next;
    logic                  rd_vld_reg, rd_vld_next;
    logic                  first_reg, first_next;
    logic [DCNT_BITS-1:0]  div_cnt_reg, div_cnt_next;
    logic                  out_valid_reg, out_valid_next;

    // Datapath registers.
    sample_t               hold_reg, hold_next;
    logic signed [SUM_BITS-1:0] sum_reg, sum_next;
    sample_t               hi_reg, hi_next;
    sample_t               lo_reg, lo_next;
    logic                  neg_reg, neg_next;
    logic [DIV_BITS-1:0]   quo_reg, quo_next;
    logic [REM_BITS-1:0]   rem_reg, rem_next;
    sample_t               echo_reg, echo_next;
    sample_t               avg_reg, avg_next;
    sample_t               max_reg, max_next;
    sample_t               min_reg, min_next;

    // Sample store with a registered read port.
    sample_t               store [WINDOW];
    sample_t               rd_data_reg;

    logic                  in_xfer;
    logic                  rd_en;
    logic [IDX_BITS-1:0]   wr_addr;
    logic [SUM_BITS-1:0]   sum_mag;
    sample_t               quo_trim;
    logic                  out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign wr_addr   = idx_inc(newest_reg);
    assign rd_en     = (state_reg == ST_SCAN) && (issue_cnt_reg != fill_reg);
    assign out_free  = !out_valid_reg || out_ready;
    assign sum_mag   = sum_reg[SUM_BITS-1] ? SUM_BITS'(-sum_reg) : SUM_BITS'(sum_reg);
    assign quo_trim  = sample_t'(quo_reg[SAMPLE_BITS-1:0]);

    assign out_valid      = out_valid_reg;
    assign sample_echo    = echo_reg;
    assign window_average = avg_reg;
    assign window_maximum = max_reg;
    assign window_minimum = min_reg;

    always_ff @(posedge clk) begin
        if (in_xfer) begin
            store[wr_addr] <= sample;
        end
        if (rd_en) begin
            rd_data_reg <= store[scan_addr_reg];
        end
    end

    always_comb begin
        logic [REM_BITS-1:0] rem_v;
        logic [DIV_BITS-1:0] quo_v;

        state_next     = state_reg;
        newest_next    = newest_reg;
        oldest_next    = oldest_reg;
        fill_next      = fill_reg;
        scan_addr_next = scan_addr_reg;
        issue_cnt_next = issue_cnt_reg;
        rd_vld_next    = 1'b0;
        first_next     = first_reg;
        div_cnt_next   = div_cnt_reg;
        out_valid_next = out_valid_reg;
        hold_next      = hold_reg;
        sum_next       = sum_reg;
        hi_next        = hi_reg;
        lo_next        = lo_reg;
        neg_next       = neg_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        echo_next      = echo_reg;
        avg_next       = avg_reg;
        max_next       = max_reg;
        min_next       = min_reg;
        rem_v          = rem_reg;
        quo_v          = quo_reg;

        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end

        // Each stored sample read last cycle goes through the shared accumulate
        // and compare unit.
        if (rd_vld_reg) begin
            sum_next   = sum_reg + SUM_BITS'(rd_data_reg);
            first_next = 1'b0;
            if (first_reg || (rd_data_reg > hi_reg)) begin
                hi_next = rd_data_reg;
            end
            if (first_reg || (rd_data_reg < lo_reg)) begin
                lo_next = rd_data_reg;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer) begin
                    // The window drops its oldest sample once full, else it grows.
                    if (fill_reg == CNT_BITS'(WINDOW)) begin
                        oldest_next = idx_inc(oldest_reg);
                    end else begin
                        fill_next = fill_reg + 1'b1;
                    end
                    newest_next    = wr_addr;
                    scan_addr_next = (fill_reg == CNT_BITS'(WINDOW)) ?
                                     idx_inc(oldest_reg) : oldest_reg;
                    issue_cnt_next = '0;
                    first_next     = 1'b1;
                    sum_next       = '0;
                    hold_next      = sample;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (rd_en) begin
                    rd_vld_next    = 1'b1;
                    scan_addr_next = idx_inc(scan_addr_reg);
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                end else if (!rd_vld_reg) begin
                    // All held samples are summed; divide the magnitude.
                    neg_next     = sum_reg[SUM_BITS-1];
                    quo_next     = DIV_BITS'(sum_mag);
                    rem_next     = '0;
                    div_cnt_next = '0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // Restoring division, four quotient bits per cycle. Quotient bits
                // shift in at the bottom as dividend bits leave at the top.
                for (int k = 0; k < DIV_STEPS; k++) begin
                    rem_v = {rem_v[REM_BITS-2:0], quo_v[DIV_BITS-1]};
                    quo_v = {quo_v[DIV_BITS-2:0], 1'b0};
                    if (rem_v >= {1'b0, fill_reg}) begin
                        rem_v    = rem_v - {1'b0, fill_reg};
                        quo_v[0] = 1'b1;
                    end
                end
                rem_next     = rem_v;
                quo_next     = quo_v;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DCNT_BITS'(DIV_CYCLES - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // The result waits here until the output register is free.
                if (out_free) begin
                    echo_next      = hold_reg;
                    avg_next       = neg_reg ? sample_t'(-quo_trim) : quo_trim;
                    max_next       = hi_reg;
                    min_next       = lo_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            newest_reg    <= IDX_BITS'(WINDOW - 1);
            oldest_reg    <= '0;
            fill_reg      <= '0;
            scan_addr_reg <= '0;
            issue_cnt_reg <= '0;
            rd_vld_reg    <= 1'b0;
            first_reg     <= 1'b0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            newest_reg    <= newest_next;
            oldest_reg    <= oldest_next;
            fill_reg      <= fill_next;
            scan_addr_reg <= scan_addr_next;
            issue_cnt_reg <= issue_cnt_next;
            rd_vld_reg    <= rd_vld_next;
            first_reg     <= first_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        hold_reg <= hold_next;
        sum_reg  <= sum_next;
        hi_reg   <= hi_next;
        lo_reg   <= lo_next;
        neg_reg  <= neg_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        echo_reg <= echo_next;
        avg_reg  <= avg_next;
        max_reg  <= max_next;
        min_reg  <= min_next;
    end

endmodule

@@ hw/rtl/swamm_checker.sv @@
`include "sliding_window_avg_max_min_unit_macros.svh"

module swamm_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input swamm_pkg::sample_t sample_echo,
    input swamm_pkg::sample_t window_average,
    input swamm_pkg::sample_t window_maximum,
    input swamm_pkg::sample_t window_minimum
);
    import swamm_pkg::*;

    // A stalled result stays valid and keeps its average.
    `SWAMM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(window_average), "result changed while stalled")

    // The unit works on one sample at a time.
    `SWAMM_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready, "input taken while busy")

    // The mean lies between the window extremes.
    `SWAMM_ASSERT(a_avg_range, !out_valid || (window_minimum <= window_average && window_average <= window_maximum), "average outside min and max")

    // The newest sample is part of the window.
    `SWAMM_ASSERT(a_echo_range, !out_valid || (window_minimum <= sample_echo && sample_echo <= window_maximum), "sample outside min and max")

endmodule

bind sliding_window_avg_max_min_unit swamm_checker u_swamm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .sample_echo    (sample_echo),
    .window_average (window_average),
    .window_maximum (window_maximum),
    .window_minimum (window_minimum)
);
